@@ hw/rtl/d2e_pkg.sv @@
// shared types and constants for the date to epoch seconds converter
// no dependencies; imported by d2e_scale and date_to_epoch_seconds_core
package d2e_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int IN_W     = YEAR_W + MONTH_W + DAY_W + HOUR_W + MIN_W + SEC_W;
    localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;

    localparam int EPOCH_W  = 38;
    localparam int OUT_DATA_W = ((EPOCH_W + 7) / 8) * 8;

    localparam int Q100_W   = 8;   // year / 100 for a 14-bit year
    localparam int MDAYS_W  = 9;   // days before the month, at most 334
    localparam int LEAPS_W  = 12;  // leap years in 1 .. year - 1
    localparam int HMS_W    = 17;  // hour, minute and second folded to seconds
    localparam int DAYS_W   = 23;
    localparam int PROD_W   = 40;
    localparam int TOTAL_W  = 41;

    // year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
    localparam int RECIP_W     = 14;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_100 = 14'd10486;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR      = 14'd1970;
    localparam logic [MONTH_W-1:0] MONTH_JAN       = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC       = 4'd12;
    localparam logic [DAYS_W-1:0]  YEAR_DAYS       = 23'd365;
    localparam logic [DAYS_W-1:0]  LEAPS_TO_EPOCH  = 23'd477;  // leap years in 1 .. 1969
    localparam logic [PROD_W-1:0]  SECS_PER_DAY    = 40'd86400;
    localparam logic [HMS_W-1:0]   SECS_PER_HOUR   = 17'd3600;
    localparam logic [HMS_W-1:0]   SECS_PER_MIN    = 17'd60;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX       = {EPOCH_W{1'b1}};

    // data enables for the two arithmetic stages at the back of the pipe
    typedef struct packed {
        logic load_mul;
        logic load_out;
    } d2e_stage_en_t;

    // days of the months that come before the given one, non-leap year
    function automatic logic [MDAYS_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

@@ hw/rtl/d2e_scale.sv @@
// day count to seconds: multiply stage and the clamping output stage
// depends on d2e_pkg
module d2e_scale (
    input  logic                          clk,
    input  d2e_pkg::d2e_stage_en_t        en,
    input  logic [d2e_pkg::DAYS_W-1:0]    days,
    input  logic [d2e_pkg::HMS_W-1:0]     hms,
    input  logic                          err,
    output logic [d2e_pkg::EPOCH_W-1:0]   epoch_seconds,
    output logic                          range_error
);
    import d2e_pkg::*;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [HMS_W-1:0]   hms_reg;
    logic               err_reg;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] less_day;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic               range_error_reg;

    assign prod_next = PROD_W'(days) * SECS_PER_DAY;

    always_ff @(posedge clk)
    begin
        if (en.load_mul)
        begin
            prod_reg <= prod_next;
            hms_reg  <= hms;
            err_reg  <= err;
        end
    end

    // the day field counts from one, so a whole day comes off the end
    assign total    = TOTAL_W'(prod_reg) + TOTAL_W'(hms_reg);
    assign less_day = total - TOTAL_W'(SECS_PER_DAY);

    always_comb
    begin
        if (err_reg)
            epoch_next = '0;
        else if (total < TOTAL_W'(SECS_PER_DAY))
            epoch_next = '0;
        else if (less_day > TOTAL_W'(EPOCH_MAX))
            epoch_next = EPOCH_MAX;
        else
            epoch_next = less_day[EPOCH_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.load_out)
        begin
            epoch_reg       <= epoch_next;
            range_error_reg <= err_reg;
        end
    end

    assign epoch_seconds = epoch_reg;
    assign range_error   = range_error_reg;

endmodule

@@ hw/rtl/date_to_epoch_seconds_core.sv @@
// top level of the calendar time to seconds-since-1970 converter
// depends on d2e_pkg and d2e_scale
//
// Converts a Gregorian date and time of day to seconds since 1970-01-01 00:00:00.
// One item is taken per cycle while the pipe has room under back-pressure; there are
// five register stages (reciprocal divide by 100 and month table, leap-year count,
// day sum, scaling by 86400, then add and clamp into the output register). Each
// stage loads whenever it or the stage after it is free, so gaps close up under
// back-pressure and up to five items can be held. A year below
// 1970 or a month outside 1 to 12 gives tuser = 1 with zero seconds; a day of
// zero in the first days of January 1970 clamps to zero, and a total past
// 2^38 - 1 clamps to that value.
module date_to_epoch_seconds_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], second[39:34]
    input  logic [d2e_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // epoch_seconds[37:0], zero fill[39:38]
    output logic [d2e_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // range_error[0]
    output logic [0:0]                        m_axis_tuser
);
    import d2e_pkg::*;

    localparam int STAGES = 5;

    logic [YEAR_W-1:0]  in_year;
    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [HOUR_W-1:0]  in_hour;
    logic [MIN_W-1:0]   in_minute;
    logic [SEC_W-1:0]   in_second;

    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  rdy;

    // stage 1
    logic [YEAR_W-1:0]           s1_year_reg;
    logic [Q100_W-1:0]           s1_q100_reg;
    logic [MDAYS_W-1:0]          s1_mdays_reg;
    logic                        s1_after_feb_reg;
    logic [DAY_W-1:0]            s1_day_reg;
    logic [HMS_W-1:0]            s1_hms_reg;
    logic                        s1_err_reg;
    logic [YEAR_W+RECIP_W-1:0]   q_prod;
    logic [HMS_W-1:0]            hms_next;
    logic                        err_next;

    // stage 2
    logic [YEAR_W-1:0]  s2_yoff_reg;
    logic [LEAPS_W-1:0] s2_leaps_reg;
    logic               s2_leap_add_reg;
    logic [MDAYS_W-1:0] s2_mdays_reg;
    logic [DAY_W-1:0]   s2_day_reg;
    logic [HMS_W-1:0]   s2_hms_reg;
    logic               s2_err_reg;
    logic [YEAR_W-1:0]  hundreds;
    logic               cent_year;
    logic [Q100_W-1:0]  q100_prev;
    logic [YEAR_W-1:0]  year_prev;
    logic               is_leap;
    logic [LEAPS_W-1:0] leaps_next;

    // stage 3
    logic [DAYS_W-1:0]  s3_days_reg;
    logic [DAYS_W-1:0]  days_next;
    logic [HMS_W-1:0]   s3_hms_reg;
    logic               s3_err_reg;

    d2e_stage_en_t      scale_en;
    logic [EPOCH_W-1:0] epoch_seconds;
    logic               range_error;

    assign in_year   = s_axis_tdata[YEAR_W-1:0];
    assign in_month  = s_axis_tdata[YEAR_W +: MONTH_W];
    assign in_day    = s_axis_tdata[YEAR_W+MONTH_W +: DAY_W];
    assign in_hour   = s_axis_tdata[YEAR_W+MONTH_W+DAY_W +: HOUR_W];
    assign in_minute = s_axis_tdata[YEAR_W+MONTH_W+DAY_W+HOUR_W +: MIN_W];
    assign in_second = s_axis_tdata[YEAR_W+MONTH_W+DAY_W+HOUR_W+MIN_W +: SEC_W];

    // a stage may load when it is empty or the next one moves on
    always_comb
    begin
        rdy[STAGES-1] = m_axis_tready || !valid_reg[STAGES-1];
        for (int k = STAGES - 2; k >= 0; k--)
            rdy[k] = rdy[k+1] || !valid_reg[k];
    end

    assign s_axis_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < STAGES; k++)
                if (rdy[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    // stage 1: divide by 100 through the reciprocal, month table, time of day
    assign q_prod   = (YEAR_W+RECIP_W)'(in_year) * (YEAR_W+RECIP_W)'(RECIP_100);
    assign hms_next = HMS_W'(in_hour) * SECS_PER_HOUR + HMS_W'(in_minute) * SECS_PER_MIN
                      + HMS_W'(in_second);
    assign err_next = (in_year < EPOCH_YEAR) || (in_month < MONTH_JAN) || (in_month > MONTH_DEC);

    always_ff @(posedge clk)
    begin
        if (rdy[0] && s_axis_tvalid)
        begin
            s1_year_reg      <= in_year;
            s1_q100_reg      <= q_prod[RECIP_SHIFT +: Q100_W];
            s1_mdays_reg     <= days_before_month(in_month);
            s1_after_feb_reg <= in_month > MONTH_FEB;
            s1_day_reg       <= in_day;
            s1_hms_reg       <= hms_next;
            s1_err_reg       <= err_next;
        end
    end

    // stage 2: leap years in 1 .. year-1 and whether this year is one
    assign hundreds   = YEAR_W'(s1_q100_reg) * YEAR_W'(100);
    assign cent_year  = s1_year_reg == hundreds;
    assign q100_prev  = s1_q100_reg - Q100_W'(cent_year);
    assign year_prev  = s1_year_reg - YEAR_W'(1);
    assign is_leap    = (s1_year_reg[1:0] == 2'b00) && (!cent_year || s1_q100_reg[1:0] == 2'b00);
    assign leaps_next = LEAPS_W'(year_prev[YEAR_W-1:2]) - LEAPS_W'(q100_prev)
                        + LEAPS_W'(q100_prev[Q100_W-1:2]);

    always_ff @(posedge clk)
    begin
        if (rdy[1] && valid_reg[0])
        begin
            s2_yoff_reg     <= s1_year_reg - EPOCH_YEAR;
            s2_leaps_reg    <= leaps_next;
            s2_leap_add_reg <= is_leap && s1_after_feb_reg;
            s2_mdays_reg    <= s1_mdays_reg;
            s2_day_reg      <= s1_day_reg;
            s2_hms_reg      <= s1_hms_reg;
            s2_err_reg      <= s1_err_reg;
        end
    end

    // stage 3: total days, still counting the day of the month from one
    assign days_next = DAYS_W'(s2_yoff_reg) * YEAR_DAYS + DAYS_W'(s2_leaps_reg)
                       - LEAPS_TO_EPOCH + DAYS_W'(s2_mdays_reg) + DAYS_W'(s2_leap_add_reg)
                       + DAYS_W'(s2_day_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[2] && valid_reg[1])
        begin
            s3_days_reg <= days_next;
            s3_hms_reg  <= s2_hms_reg;
            s3_err_reg  <= s2_err_reg;
        end
    end

    // stages 4 and 5
    assign scale_en.load_mul = rdy[3] && valid_reg[2];
    assign scale_en.load_out = rdy[4] && valid_reg[3];

    d2e_scale u_scale (
        .clk           (clk),
        .en            (scale_en),
        .days          (s3_days_reg),
        .hms           (s3_hms_reg),
        .err           (s3_err_reg),
        .epoch_seconds (epoch_seconds),
        .range_error   (range_error)
    );

    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = OUT_DATA_W'(epoch_seconds);
    assign m_axis_tuser  = range_error;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("range error item carries nonzero seconds");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> s_axis_tready)
        else $error("input refused with the first stage empty");

    a_room_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid && !m_axis_tready
        |-> !valid_reg[0] || !valid_reg[1] || !valid_reg[2] || !valid_reg[3])
        else $error("input taken with a full pipe and a stalled output");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[2] && !rdy[3] |=> valid_reg[2])
        else $error("stalled stage dropped its item");

endmodule
